>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the sample ring RTL. Define NO_ASSERTIONS to
// drop every check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequence must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequence must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/msr_pkg.sv
// ----------------------------------------------------------------------------
// msr_pkg
// Types and constants shared by the multi-channel sample ring modules.
// ----------------------------------------------------------------------------
package msr_pkg;

    localparam int EPOCH_W = 32;
    localparam int TEMP_W  = 32;
    localparam int CNT_W   = 7;

    // Request kinds carried on the input tuser bit
    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    // Query sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } t_state;

    // One stored sample
    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [TEMP_W-1:0]  temp;
    } t_sample;

    // One query result
    typedef struct packed {
        logic               found;
        logic [EPOCH_W-1:0] epoch;
        logic [TEMP_W-1:0]  temp;
        logic [CNT_W-1:0]   written;
        logic               last;
    } t_result;

    // Query launch from the front end to the sequencer
    typedef struct packed {
        logic               start;
        logic               invalid;
        logic [EPOCH_W-1:0] since;
        logic [CNT_W-1:0]   max_out;
    } t_query_cmd;

endpackage

>>> rtl/multi_channel_sample_ring.sv
// ----------------------------------------------------------------------------
// multi_channel_sample_ring
// Per-channel overwrite-oldest rings of timestamped samples with
// epoch-filtered queries.
// ----------------------------------------------------------------------------
// Requests enter on the slave stream: tuser selects add (0) or query (1),
// tdata carries channel, sample, query epoch and result limit. An add to a
// valid channel writes the sample at the channel head when accepted and gives
// no result. A query walks the channel from oldest to newest, one store read
// per cycle while not stalled, and sends each sample at or after the query
// epoch, up to the result limit, on the master stream (tuser = found, tlast
// on the final result); no match or a bad channel gives one empty result
// marked last. A query reads at most the channel's fill count (never more
// than DEPTH) through the single store read port, and holds the slave side
// closed until its last result is loaded into the output register. Each
// match waits for the next so the final one can carry tlast. The next
// request is taken while the last result waits in the output register; a
// receiver stall freezes the walk when a match must wait, without loss.
// Reset clears head pointers and fill counts, not the sample store.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_channel_sample_ring #(
    parameter int CHANNELS = 5,
    parameter int DEPTH    = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Request stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata: sensor[2:0], new_epoch[34:3], new_temp[66:35],
    //        since_epoch[98:67], max_out[105:99], zero pad[111:106]
    input  logic [111:0] i_s_tdata,
    // tuser: op[0]
    input  logic         i_s_tuser,
    // Result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // tdata: sample_epoch[31:0], sample_temp[63:32], written_so_far[70:64],
    //        zero pad[71]
    output logic [71:0]  o_m_tdata,
    // tuser: found[0]
    output logic         o_m_tuser,
    // tlast: last result of a query
    output logic         o_m_tlast
);
    import msr_pkg::*;

    localparam int CHW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IW        = $clog2(DEPTH);
    localparam int CW        = $clog2(DEPTH + 1);
    localparam int SW        = CW + 1;
    localparam int MEM_DEPTH = CHANNELS * (2 ** IW);
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam logic [4:0] CH_LIM = 5'(CHANNELS);

    // Request fields
    logic               w_accept;
    t_op                w_op;
    logic [2:0]         w_sensor;
    logic [EPOCH_W-1:0] w_new_epoch;
    logic [TEMP_W-1:0]  w_new_temp;
    logic [EPOCH_W-1:0] w_since;
    logic [CNT_W-1:0]   w_max_out;
    logic               w_ch_ok;
    logic [CHW-1:0]     w_ch;

    // Per-channel ring pointers
    logic [IW-1:0] r_head [0:CHANNELS-1];
    logic [CW-1:0] r_fill [0:CHANNELS-1];
    logic [IW-1:0] w_head;
    logic [CW-1:0] w_fill;
    logic [IW-1:0] n_head;
    logic [CW-1:0] n_fill;
    logic [SW-1:0] w_start_sum;
    logic [IW-1:0] w_start_idx;
    logic          w_add;

    // Store and sequencer links
    t_query_cmd    w_cmd;
    logic          w_busy;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    t_sample       w_rd_data;
    t_sample       w_wr_data;
    logic          w_push;
    t_result       w_res;
    logic          w_out_free;

    // Output register
    logic    r_out_vld;
    t_result r_out;

    // Unpack the request
    always_comb begin
        w_op        = t_op'(i_s_tuser);
        w_sensor    = i_s_tdata[2:0];
        w_new_epoch = i_s_tdata[34:3];
        w_new_temp  = i_s_tdata[66:35];
        w_since     = i_s_tdata[98:67];
        w_max_out   = i_s_tdata[105:99];
        w_ch_ok     = ({2'b00, w_sensor} < CH_LIM);
        w_ch        = CHW'(w_sensor);
        o_s_tready  = !w_busy;
        w_accept    = i_s_tvalid && o_s_tready;
    end

    // Look up the channel pointers, advance head and fill for an add
    always_comb begin
        w_head      = r_head[w_ch];
        w_fill      = r_fill[w_ch];
        w_add       = w_accept && (w_op == OP_ADD) && w_ch_ok;
        n_head      = (w_head == IW'(DEPTH - 1)) ? '0 : w_head + IW'(1);
        n_fill      = (w_fill == CW'(DEPTH)) ? w_fill : w_fill + CW'(1);
        w_start_sum = SW'(w_head) + SW'(DEPTH) - SW'(w_fill);
        w_start_idx = (w_start_sum >= SW'(DEPTH)) ? IW'(w_start_sum - SW'(DEPTH))
                                                  : IW'(w_start_sum);
        w_wr_data   = '{epoch: w_new_epoch, temp: w_new_temp};
        w_cmd       = '{start:   w_accept && (w_op == OP_QUERY),
                        invalid: !w_ch_ok,
                        since:   w_since,
                        max_out: w_max_out};
    end

    // Hold the ring pointers; clear at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_head[i] <= '0;
                r_fill[i] <= '0;
            end
        end else if (w_add) begin
            r_head[w_ch] <= n_head;
            r_fill[w_ch] <= n_fill;
        end
    end

    msr_mem #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_add),
        .i_wr_addr (AW'({w_ch, w_head})),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    msr_walk #(
        .CHANNELS (CHANNELS),
        .DEPTH    (DEPTH)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_ch        (w_ch),
        .i_start_idx (w_start_idx),
        .i_cnt       (w_fill),
        .o_busy      (w_busy),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_push      (w_push),
        .o_res       (w_res),
        .i_out_free  (w_out_free)
    );

    // Output register: load a result when empty or being drained
    assign w_out_free = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= w_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push && w_out_free) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {1'b0, r_out.written, r_out.temp, r_out.epoch};
    assign o_m_tuser  = r_out.found;
    assign o_m_tlast  = r_out.last;

    // A result that could not be handed over is offered again
    `ASSERT_NEXT(a_push_held, i_clk, i_rst_n, w_push && !w_out_free, w_push)
    // An accepted query keeps the request side closed while it walks
    `ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, w_accept && (w_op == OP_QUERY), w_busy)
    // The empty marker always ends its query
    `ASSERT_IMPLIES(a_empty_last, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, o_m_tlast)
    // A carried sample always counts itself
    `ASSERT_IMPLIES(a_found_count, i_clk, i_rst_n, o_m_tvalid && o_m_tuser,
                    o_m_tdata[70:64] != 7'd0)

endmodule

>>> rtl/msr_mem.sv
// ----------------------------------------------------------------------------
// msr_mem
// Sample store: one write port, one read port with registered read data.
// The read register holds its value while the read enable is low.
// ----------------------------------------------------------------------------
module msr_mem #(
    parameter int MEM_DEPTH = 320
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [$clog2(MEM_DEPTH)-1:0] i_wr_addr,
    input  msr_pkg::t_sample             i_wr_data,
    input  logic                         i_rd_en,
    input  logic [$clog2(MEM_DEPTH)-1:0] i_rd_addr,
    output msr_pkg::t_sample             o_rd_data
);
    import msr_pkg::*;

    t_sample r_mem [0:MEM_DEPTH-1];
    t_sample r_rd_data;

    // Write the sample at the head slot
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one entry a cycle, hold while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/msr_walk.sv
// ----------------------------------------------------------------------------
// msr_walk
// Query sequencer: walks one channel from oldest to newest sample, one
// memory read per cycle unless stalled by the output, and keeps one matching
// sample pending so that the final result of a query can be flagged last.
// ----------------------------------------------------------------------------
module msr_walk #(
    parameter int CHANNELS = 5,
    parameter int DEPTH    = 64
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  msr_pkg::t_query_cmd                           i_cmd,
    input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] i_ch,
    input  logic [$clog2(DEPTH)-1:0]                      i_start_idx,
    input  logic [$clog2(DEPTH+1)-1:0]                    i_cnt,
    output logic                                          o_busy,
    output logic                                          o_rd_en,
    output logic [$clog2(CHANNELS*(2**$clog2(DEPTH)))-1:0] o_rd_addr,
    input  msr_pkg::t_sample                              i_rd_data,
    output logic                                          o_push,
    output msr_pkg::t_result                              o_res,
    input  logic                                          i_out_free
);
    import msr_pkg::*;

    localparam int CHW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IW        = $clog2(DEPTH);
    localparam int CW        = $clog2(DEPTH + 1);
    localparam int MEM_DEPTH = CHANNELS * (2 ** IW);
    localparam int AW        = $clog2(MEM_DEPTH);

    t_state              r_state, n_state;
    logic [CHW-1:0]      r_ch, n_ch;
    logic [IW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_iss, n_iss;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [EPOCH_W-1:0]  r_since, n_since;
    logic [CNT_W-1:0]    r_max, n_max;
    logic [CNT_W-1:0]    r_wr, n_wr;
    logic                r_rd_vld, n_rd_vld;
    logic                r_pend_vld, n_pend_vld;
    t_result             r_pend, n_pend;

    logic w_walk;
    logic w_match;
    logic w_stall;
    logic w_issue;
    logic w_done;

    // Decode the walk step
    always_comb begin
        w_walk  = (r_state == ST_WALK);
        w_match = w_walk && r_rd_vld && (i_rd_data.epoch >= r_since) && (r_wr < r_max);
        w_stall = w_match && r_pend_vld && !i_out_free;
        w_issue = w_walk && !w_stall && (r_iss != r_cnt) && (r_wr < r_max);
        w_done  = w_walk && !r_rd_vld && ((r_iss == r_cnt) || (r_wr >= r_max));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd.start) begin
                    n_state = i_cmd.invalid ? ST_FLUSH : ST_WALK;
                end
            end
            ST_WALK: begin
                if (w_done) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Next walk counters and pending sample
    always_comb begin
        n_ch       = r_ch;
        n_idx      = r_idx;
        n_iss      = r_iss;
        n_cnt      = r_cnt;
        n_since    = r_since;
        n_max      = r_max;
        n_wr       = r_wr;
        n_rd_vld   = r_rd_vld;
        n_pend_vld = r_pend_vld;
        n_pend     = r_pend;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd.start) begin
                    n_ch       = i_ch;
                    n_idx      = i_start_idx;
                    n_cnt      = i_cnt;
                    n_iss      = '0;
                    n_since    = i_cmd.since;
                    n_max      = i_cmd.max_out;
                    n_wr       = '0;
                    n_rd_vld   = 1'b0;
                    n_pend_vld = 1'b0;
                end
            end
            ST_WALK: begin
                if (!w_stall) begin
                    n_rd_vld = w_issue;
                    if (w_issue) begin
                        n_idx = (r_idx == IW'(DEPTH - 1)) ? '0 : r_idx + IW'(1);
                        n_iss = r_iss + CW'(1);
                    end
                    if (w_match) begin
                        n_wr       = r_wr + CNT_W'(1);
                        n_pend_vld = 1'b1;
                        n_pend     = '{found:   1'b1,
                                       epoch:   i_rd_data.epoch,
                                       temp:    i_rd_data.temp,
                                       written: r_wr + CNT_W'(1),
                                       last:    1'b0};
                    end
                end
            end
            ST_FLUSH: begin
                n_rd_vld = 1'b0;
            end
            default: begin
                n_rd_vld = 1'b0;
            end
        endcase
    end

    // Outputs: hand over the pending sample when a newer match replaces it,
    // and the final result (or the empty marker) at the end of the walk
    always_comb begin
        o_busy    = (r_state != ST_IDLE);
        o_rd_en   = w_issue;
        o_rd_addr = AW'({r_ch, r_idx});
        o_push    = 1'b0;
        o_res     = r_pend;
        unique case (r_state)
            ST_IDLE: begin
                o_push = 1'b0;
            end
            ST_WALK: begin
                o_push = w_match && r_pend_vld;
            end
            ST_FLUSH: begin
                o_push = 1'b1;
                if (r_pend_vld) begin
                    o_res.last = 1'b1;
                end else begin
                    o_res = '{found: 1'b0, epoch: '0, temp: '0, written: '0, last: 1'b1};
                end
            end
            default: o_push = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= n_rd_vld;
            r_pend_vld <= n_pend_vld;
        end
    end

    // Walk payload registers
    always_ff @(posedge i_clk) begin
        r_ch    <= n_ch;
        r_idx   <= n_idx;
        r_iss   <= n_iss;
        r_cnt   <= n_cnt;
        r_since <= n_since;
        r_max   <= n_max;
        r_wr    <= n_wr;
        r_pend  <= n_pend;
    end

endmodule
